### hdl/lage_pkg.sv
// Shared types, constants and the cell update rule of the life grid engine.
package lage_pkg;

    localparam int OP_W        = 2;
    localparam int COORD_W     = 6;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int NCOUNT_W    = 4;

    localparam logic [NCOUNT_W-1:0] BIRTH_COUNT = NCOUNT_W'(3);
    localparam logic [NCOUNT_W-1:0] SURVIVE_LOW = NCOUNT_W'(2);

    // register word index (paddr[2])
    localparam logic REG_RULE_SELECT = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic {
        RULE_CONWAY = 1'b0,
        RULE_PARITY = 1'b1
    } rule_t;

    // new state of one cell from its state and live neighbour count
    function automatic logic next_cell(rule_t rule, logic alive, logic [NCOUNT_W-1:0] n);
        logic res;
        if (rule == RULE_PARITY) begin
            res = n[0];
        end else begin
            res = (n == BIRTH_COUNT) || (alive && (n == SURVIVE_LOW));
        end
        return res;
    endfunction

endpackage

### hdl/lage_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module lage_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/life_automaton_grid_engine_core.sv
// Top level of the life grid engine: cell store, generation sequencer and ports.
//
// The grid is kept in one RAM, one row of GRID_WIDTH cells per word, GRID_HEIGHT
// words. After reset a clearing pass writes every row dead, during which s_tready
// is low (register writes are taken as ever).
// Each input beat yields exactly one result beat. Steps per beat, counted from
// acceptance to the result being shown on m_tvalid: read and write do one RAM
// read, then the result or the read-modify-write; a read or write outside the
// grid goes straight to the result; clear writes one row per cycle, then shows
// the result; advance runs the single neighbour count and rule unit, which
// updates one cell per cycle while three row registers slide across the grid;
// each row also takes a RAM fetch, a fill step and a write-back, and priming
// the first row takes one extra fetch and fill.
// The new row is written back in place once the row below has been fetched,
// so no second grid store is needed. s_tready
// is high only when the engine is idle; the next beat is taken in the cycle
// after the result beat has left. rule_select (byte address 0): 0 = B3/S23,
// 1 = parity rule; it should be changed only while the engine is idle.
module life_automaton_grid_engine_core #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lage_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lage_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lage_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // command stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: operation[1:0], column[7:2], row[13:8], cell_in[14], zero[15]
    input  logic [lage_pkg::S_TDATA_W-1:0]     s_tdata,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: cell_out[0], zero[7:1]
    output logic [lage_pkg::M_TDATA_W-1:0]     m_tdata
);
    import lage_pkg::*;

    localparam int XW = $clog2(GRID_WIDTH);
    localparam int YW = $clog2(GRID_HEIGHT);
    localparam int FW = $clog2(GRID_HEIGHT + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_RMW,
        S_A_FETCH,
        S_A_FILL,
        S_A_CELL,
        S_A_WB,
        S_RESP
    } state_t;

    // input beat fields
    op_t                s_operation;
    logic [COORD_W-1:0] s_column;
    logic [COORD_W-1:0] s_row;
    logic               s_cell_in;
    logic               s_inside;

    assign s_operation = op_t'(s_tdata[1:0]);
    assign s_column    = s_tdata[7:2];
    assign s_row       = s_tdata[13:8];
    assign s_cell_in   = s_tdata[14];
    assign s_inside    = (32'(s_column) < GRID_WIDTH) && (32'(s_row) < GRID_HEIGHT);

    // control and datapath registers
    state_t              state_reg;
    rule_t               rule_reg;
    logic                boot_reg;
    op_t                 op_reg;
    logic [XW-1:0]       col_reg;
    logic [YW-1:0]       row_reg;
    logic                cell_reg;
    logic                cell_out_reg;
    logic [YW-1:0]       y_reg;
    logic [FW-1:0]       fetch_reg;
    logic [XW-1:0]       x_reg;
    // old-grid rows y and y+1, kept across the in-place write-back
    logic [GRID_WIDTH-1:0] mid_reg, dn_reg;
    // sliding copies, bit 0 is the cell column under update
    logic [GRID_WIDTH-1:0] su_reg, sm_reg, sd_reg;
    logic                  lu_reg, lm_reg, ld_reg;
    logic [GRID_WIDTH-1:0] new_reg;

    // RAM port
    logic                  ram_we;
    logic [YW-1:0]         ram_waddr;
    logic [GRID_WIDTH-1:0] ram_wdata;
    logic [YW-1:0]         ram_raddr;
    logic [GRID_WIDTH-1:0] ram_rdata;

    lage_ram #(
        .WIDTH (GRID_WIDTH),
        .DEPTH (GRID_HEIGHT)
    ) u_grid (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration
    logic cfg_write;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_RULE_SELECT) ?
                       {{(APB_DATA_W-1){1'b0}}, rule_reg} : '0;

    // shared neighbour count and rule unit: one cell per cycle
    logic [NCOUNT_W-1:0] ncount;
    logic                cell_next;
    assign ncount = NCOUNT_W'(lu_reg) + NCOUNT_W'(lm_reg) + NCOUNT_W'(ld_reg)
                  + NCOUNT_W'(su_reg[0]) + NCOUNT_W'(sd_reg[0])
                  + NCOUNT_W'(su_reg[1]) + NCOUNT_W'(sm_reg[1]) + NCOUNT_W'(sd_reg[1]);
    assign cell_next = next_cell(rule_reg, sm_reg[0], ncount);

    // row read-modify-write for a single cell
    logic [GRID_WIDTH-1:0] rmw_row;
    always_comb begin
        rmw_row          = ram_rdata;
        rmw_row[col_reg] = cell_reg;
    end

    // row fetched past the bottom edge is all dead
    logic                  fetch_in_grid;
    logic [GRID_WIDTH-1:0] fill_row;
    assign fetch_in_grid = 32'(fetch_reg) < GRID_HEIGHT;
    assign fill_row      = fetch_in_grid ? ram_rdata : '0;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = y_reg;
        ram_wdata = '0;
        ram_raddr = YW'(s_row);
        case (state_reg)
            S_IDLE: begin
                ram_raddr = YW'(s_row);
            end
            S_CLR: begin
                ram_we = 1'b1;
            end
            S_RMW: begin
                ram_we    = (op_reg == OP_WRITE);
                ram_waddr = row_reg;
                ram_wdata = rmw_row;
            end
            S_A_FETCH: begin
                ram_raddr = YW'(fetch_reg);
            end
            S_A_WB: begin
                ram_we    = 1'b1;
                ram_wdata = new_reg;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            rule_reg     <= RULE_CONWAY;
            boot_reg     <= 1'b1;
            y_reg        <= '0;
            cell_out_reg <= 1'b0;
        end else begin
            if (cfg_write && (paddr[2] == REG_RULE_SELECT)) begin
                rule_reg <= rule_t'(pwdata[0]);
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg       <= s_operation;
                        col_reg      <= XW'(s_column);
                        row_reg      <= YW'(s_row);
                        cell_reg     <= s_cell_in;
                        cell_out_reg <= 1'b0;
                        case (s_operation)
                            OP_READ, OP_WRITE: begin
                                state_reg <= s_inside ? S_RMW : S_RESP;
                            end
                            OP_ADVANCE: begin
                                y_reg     <= '0;
                                fetch_reg <= '0;
                                mid_reg   <= '0;
                                dn_reg    <= '0;
                                state_reg <= S_A_FETCH;
                            end
                            default: begin
                                y_reg     <= '0;
                                boot_reg  <= 1'b0;
                                state_reg <= S_CLR;
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    if (y_reg == YW'(GRID_HEIGHT - 1)) begin
                        state_reg <= boot_reg ? S_IDLE : S_RESP;
                    end else begin
                        y_reg <= y_reg + YW'(1);
                    end
                end
                S_RMW: begin
                    if (op_reg == OP_READ) begin
                        cell_out_reg <= ram_rdata[col_reg];
                    end
                    state_reg <= S_RESP;
                end
                S_A_FETCH: begin
                    state_reg <= S_A_FILL;
                end
                S_A_FILL: begin
                    mid_reg <= dn_reg;
                    dn_reg  <= fill_row;
                    if (fetch_reg == '0) begin
                        // prime: need rows 0 and 1 before the first row
                        fetch_reg <= FW'(1);
                        state_reg <= S_A_FETCH;
                    end else begin
                        su_reg    <= mid_reg;
                        sm_reg    <= dn_reg;
                        sd_reg    <= fill_row;
                        lu_reg    <= 1'b0;
                        lm_reg    <= 1'b0;
                        ld_reg    <= 1'b0;
                        x_reg     <= '0;
                        state_reg <= S_A_CELL;
                    end
                end
                S_A_CELL: begin
                    new_reg <= {cell_next, new_reg[GRID_WIDTH-1:1]};
                    lu_reg  <= su_reg[0];
                    lm_reg  <= sm_reg[0];
                    ld_reg  <= sd_reg[0];
                    // zeros shift in: the right edge reads dead
                    su_reg  <= {1'b0, su_reg[GRID_WIDTH-1:1]};
                    sm_reg  <= {1'b0, sm_reg[GRID_WIDTH-1:1]};
                    sd_reg  <= {1'b0, sd_reg[GRID_WIDTH-1:1]};
                    if (x_reg == XW'(GRID_WIDTH - 1)) begin
                        state_reg <= S_A_WB;
                    end else begin
                        x_reg <= x_reg + XW'(1);
                    end
                end
                S_A_WB: begin
                    if (y_reg == YW'(GRID_HEIGHT - 1)) begin
                        state_reg <= S_RESP;
                    end else begin
                        y_reg     <= y_reg + YW'(1);
                        fetch_reg <= fetch_reg + FW'(1);
                        state_reg <= S_A_FETCH;
                    end
                end
                S_RESP: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_RESP);
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, cell_out_reg};

endmodule

### tb/sv/tb_life_automaton_grid_engine_core.sv
// Self-checking testbench for the life grid engine: command stream, rule register, cell results.
module tb_life_automaton_grid_engine_core;
    import lage_pkg::*;

    localparam int COLS          = 64;
    localparam int ROWS          = 64;
    localparam int RUN_LIMIT     = 60_000_000;   // time units, far beyond the slowest clean run
    localparam int PHASE_BEATS   = 500;          // random command beats per phase
    localparam int ADV_PER_PHASE = 20;           // an advance walks the whole grid, keep them few
    localparam int HOLD_CYCLES   = 400;          // long result hold-off
    localparam int TAIL_CYCLES   = 100;          // quiet cycles after the last result
    localparam int MAX_REPORTS   = 10;

    localparam logic [APB_ADDR_W-1:0] RULE_ADDR  = APB_ADDR_W'(0);
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = APB_ADDR_W'(4);  // no register here

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // operation[1:0], column[7:2], row[13:8], cell_in[14]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // cell_out[0], zero[7:1]

    life_automaton_grid_engine_core #(
        .GRID_WIDTH (COLS),
        .GRID_HEIGHT(ROWS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // one pending result beat, with the command that caused it for messages
    typedef struct {
        bit         exp_bit;
        op_t        op;
        bit [5:0]   col;
        bit [5:0]   row;
    } cell_due_t;

    // directed command; 'typed' marks rows whose result is written out here
    typedef struct packed {
        op_t        op;
        logic [5:0] col;
        logic [5:0] row;
        logic       cin;
        logic       typed;
        logic       want;
    } dir_row_t;

    // Corners, an edge blinker (no wrap across the right edge), clear,
    // alternating address bits and writing a dead cell.
    localparam dir_row_t DIRECTED [25] = '{
        '{OP_READ,    6'd0,  6'd0,  1'b0, 1'b1, 1'b0},   // all dead after reset
        '{OP_READ,    6'd63, 6'd63, 1'b1, 1'b1, 1'b0},
        '{OP_WRITE,   6'd0,  6'd0,  1'b1, 1'b1, 1'b0},   // non-read beats return 0
        '{OP_WRITE,   6'd63, 6'd63, 1'b1, 1'b1, 1'b0},
        '{OP_WRITE,   6'd63, 6'd0,  1'b1, 1'b1, 1'b0},
        '{OP_WRITE,   6'd0,  6'd63, 1'b1, 1'b1, 1'b0},
        '{OP_READ,    6'd0,  6'd0,  1'b0, 1'b1, 1'b1},
        '{OP_READ,    6'd63, 6'd0,  1'b0, 1'b1, 1'b1},
        '{OP_READ,    6'd63, 6'd63, 1'b0, 1'b1, 1'b1},
        '{OP_WRITE,   6'd63, 6'd31, 1'b1, 1'b1, 1'b0},
        '{OP_WRITE,   6'd63, 6'd32, 1'b1, 1'b1, 1'b0},
        '{OP_WRITE,   6'd63, 6'd33, 1'b1, 1'b1, 1'b0},
        '{OP_ADVANCE, 6'd17, 6'd40, 1'b1, 1'b1, 1'b0},
        '{OP_READ,    6'd0,  6'd0,  1'b0, 1'b1, 1'b0},   // lone corner cell dies
        '{OP_READ,    6'd62, 6'd32, 1'b0, 1'b0, 1'b0},
        '{OP_READ,    6'd63, 6'd32, 1'b0, 1'b0, 1'b0},
        '{OP_READ,    6'd0,  6'd32, 1'b0, 1'b0, 1'b0},
        '{OP_READ,    6'd63, 6'd31, 1'b0, 1'b0, 1'b0},
        '{OP_CLEAR,   6'd5,  6'd9,  1'b1, 1'b1, 1'b0},
        '{OP_READ,    6'd62, 6'd32, 1'b0, 1'b1, 1'b0},
        '{OP_WRITE,   6'd21, 6'd42, 1'b1, 1'b1, 1'b0},
        '{OP_READ,    6'd21, 6'd42, 1'b0, 1'b1, 1'b1},
        '{OP_WRITE,   6'd42, 6'd21, 1'b0, 1'b1, 1'b0},   // dead write to a dead cell
        '{OP_WRITE,   6'd21, 6'd42, 1'b0, 1'b1, 1'b0},
        '{OP_READ,    6'd21, 6'd42, 1'b0, 1'b1, 1'b0}
    };

    // predicted engine state
    bit        life_now [ROWS][COLS];
    rule_t     rule_now;
    cell_due_t cell_out_due [$];

    int errors;
    int beats_sent;
    int adv_left;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int n_read, n_write, n_advance, n_clear, n_live_reads;

    // ---------------------------------------------------------------- predictor

    // live cells among the eight neighbours; beyond the edges counts as dead
    function automatic int live_around(int r, int c);
        int n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < ROWS &&
                    c + dc >= 0 && c + dc < COLS) begin
                    n += life_now[r+dr][c+dc];
                end
            end
        end
        return n;
    endfunction

    // every new cell comes from the old grid
    function automatic void step_generation();
        bit nxt [ROWS][COLS];
        int n;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                n = live_around(r, c);
                if (rule_now == RULE_PARITY) begin
                    nxt[r][c] = n[0];
                end else begin
                    nxt[r][c] = (n == BIRTH_COUNT) || (life_now[r][c] && n == SURVIVE_LOW);
                end
            end
        end
        life_now = nxt;
    endfunction

    // apply one command to the predicted grid, return the expected cell_out
    function automatic bit apply_command(op_t op, bit [5:0] col, bit [5:0] row, bit cin);
        bit res = 1'b0;
        case (op)
            OP_READ: begin
                res = life_now[row][col];
            end
            OP_WRITE: begin
                life_now[row][col] = cin;
            end
            OP_ADVANCE: begin
                step_generation();
            end
            default: begin
                for (int r = 0; r < ROWS; r++) begin
                    for (int c = 0; c < COLS; c++) begin
                        life_now[r][c] = 1'b0;
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic note_mismatch(string what);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("MISMATCH @%0t: %s", $time, what);
        end
    endtask

    // ---------------------------------------------------------------- clock, watchdog

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("timeout with %0d result beats outstanding", cell_out_due.size());
        $display("life_automaton_grid_engine_core verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- result side

    // m_tready changes on the falling edge; a hold-off request wins over random idling
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // every result beat pops the oldest expectation
    always @(posedge aclk) begin : result_check
        cell_due_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (cell_out_due.size() == 0) begin
                note_mismatch($sformatf("result beat %h with nothing pending", m_tdata));
            end else begin
                due = cell_out_due.pop_front();
                if (m_tdata[0] !== due.exp_bit || m_tdata[M_TDATA_W-1:1] !== '0) begin
                    note_mismatch($sformatf("%s col %0d row %0d: cell_out exp %0b got %b, pad got %b",
                        due.op.name(), due.col, due.row, due.exp_bit, m_tdata[0],
                        m_tdata[M_TDATA_W-1:1]));
                end
                if (due.op == OP_READ && m_tdata[0] === 1'b1) begin
                    n_live_reads++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- command side

    // offer one command beat; the prediction is made at the accepting edge
    task automatic send_beat(op_t op, bit [5:0] col, bit [5:0] row, bit cin,
                             bit typed, bit want);
        cell_due_t due;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, cin, row, col, op};
        do @(posedge aclk); while (!s_tready);
        due.exp_bit = apply_command(op, col, row, cin);
        if (typed) begin
            due.exp_bit = want;
        end
        due.op  = op;
        due.col = col;
        due.row = row;
        cell_out_due = {cell_out_due, due};
        beats_sent++;
        case (op)
            OP_READ:    n_read++;
            OP_WRITE:   n_write++;
            OP_ADVANCE: n_advance++;
            default:    n_clear++;
        endcase
    endtask

    task automatic issue(op_t op, int col, int row, bit cin);
        send_beat(op, col[5:0], row[5:0], cin, 1'b0, 1'b0);
    endtask

    // advance only while this phase's budget lasts; ignored fields are random
    task automatic issue_advance();
        if (adv_left > 0) begin
            adv_left--;
            issue(OP_ADVANCE, $urandom_range(COLS-1), $urandom_range(ROWS-1), $urandom_range(1));
        end
    endtask

    // drop tvalid and wait until every result beat has come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (cell_out_due.size() != 0) @(negedge aclk);
    endtask

    // ---------------------------------------------------------------- register port

    task automatic cfg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == RULE_ADDR) begin
            rule_now = rule_t'(value[0]);   // upper bits are dropped
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_rule_readback();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= RULE_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DATA_W'(rule_now)) begin
            note_mismatch($sformatf("rule_select readback exp %0d got %h", rule_now, prdata));
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ---------------------------------------------------------------- random stimulus

    // seed a small patch (often against an edge or corner), run up to three
    // generations, then probe cells in and around the patch
    task automatic pattern_burst();
        int w, h, ox, oy, c, r, gens;
        w  = $urandom_range(2, 6);
        h  = $urandom_range(2, 6);
        ox = $urandom_range(1) ? ($urandom_range(1) ? 0 : COLS - w) : $urandom_range(COLS - w);
        oy = $urandom_range(1) ? ($urandom_range(1) ? 0 : ROWS - h) : $urandom_range(ROWS - h);
        for (r = oy; r < oy + h; r++) begin
            for (c = ox; c < ox + w; c++) begin
                if ($urandom_range(99) < 50) begin
                    issue(OP_WRITE, c, r, $urandom_range(99) < 80);
                end
            end
        end
        gens = $urandom_range(1) + (($urandom_range(7) == 0) ? 2 : 0);
        repeat (gens) issue_advance();
        repeat ($urandom_range(4, 12)) begin
            c = ox - 2 + $urandom_range(w + 3);
            r = oy - 2 + $urandom_range(h + 3);
            c = (c < 0) ? 0 : (c >= COLS) ? COLS - 1 : c;
            r = (r < 0) ? 0 : (r >= ROWS) ? ROWS - 1 : r;
            issue(OP_READ, c, r, $urandom_range(1));
        end
    endtask

    // scattered reads and writes anywhere in the grid, now and then an advance
    task automatic noise_beat();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            issue(OP_READ, $urandom_range(COLS-1), $urandom_range(ROWS-1), $urandom_range(1));
        end else if (pick < 92 || adv_left == 0) begin
            issue(OP_WRITE, $urandom_range(COLS-1), $urandom_range(ROWS-1), $urandom_range(1));
        end else begin
            issue_advance();
        end
    endtask

    // one random phase; halfway the sender waits for all results, and with
    // long_hold the receiver then stalls while commands keep coming
    task automatic run_phase(int s_pct, int r_pct, bit long_hold);
        int goal, pause_at, pick;
        bit paused;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        adv_left      = ADV_PER_PHASE;
        goal          = beats_sent + PHASE_BEATS;
        pause_at      = beats_sent + PHASE_BEATS / 2;
        paused        = 1'b0;
        while (beats_sent < goal) begin
            if (!paused && beats_sent >= pause_at) begin
                paused = 1'b1;
                drain();
                if (long_hold) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            pick = $urandom_range(99);
            if (pick < 65) begin
                pattern_burst();
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 5)) noise_beat();
            end else begin
                issue(OP_CLEAR, $urandom_range(COLS-1), $urandom_range(ROWS-1), $urandom_range(1));
            end
        end
        drain();
    endtask

    // ---------------------------------------------------------------- main sequence

    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        rule_now = RULE_CONWAY;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // reset value of the rule, then the directed table under Conway;
        // the engine's clearing pass holds s_tready low meanwhile
        check_rule_readback();
        send_idle_pct = 18;
        recv_idle_pct = 88;
        for (int i = 0; i < $size(DIRECTED); i++) begin
            send_beat(DIRECTED[i].op, DIRECTED[i].col, DIRECTED[i].row, DIRECTED[i].cin,
                      DIRECTED[i].typed, DIRECTED[i].want);
        end
        drain();

        // phase A: parity rule, slow receiver
        cfg_write(RULE_ADDR, APB_DATA_W'(RULE_PARITY));
        check_rule_readback();
        run_phase(18, 88, 1'b0);

        // phase B: Conway via a word with every upper bit set, slow sender
        cfg_write(RULE_ADDR, 32'hFFFF_FFFE);
        check_rule_readback();
        run_phase(88, 18, 1'b0);

        // phase C: parity again; a write to the unused address must not touch it
        cfg_write(RULE_ADDR, APB_DATA_W'(RULE_PARITY));
        cfg_write(SPARE_ADDR, '0);
        check_rule_readback();
        run_phase(0, 0, 1'b1);

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d command beats: %0d reads (%0d live), %0d writes, %0d advances, %0d clears",
                 beats_sent, n_read, n_live_reads, n_write, n_advance, n_clear);
        $display("both rules, edge patches, long result stall; %0d mismatches", errors);
        if (errors == 0 && cell_out_due.size() == 0) begin
            $display("life_automaton_grid_engine_core verification clean");
        end else begin
            $display("life_automaton_grid_engine_core verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/lage_pkg.sv
hdl/lage_ram.sv
hdl/life_automaton_grid_engine_core.sv
tb/sv/tb_life_automaton_grid_engine_core.sv
